[rtl/lcdr_pkg.sv]
package lcdr_pkg;

	localparam int LCDR_COLUMNS = 16;

	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] CMD_LINE0  = 8'h80;
	localparam logic [7:0] CMD_LINE1  = 8'hC0;

	localparam int INIT_LEN = 14;
	localparam logic [3:0] INIT_LAST  = 4'(INIT_LEN - 1);
	localparam logic [1:0] REF_LAST   = 2'd3;

	typedef enum logic [1:0] {
		REQ_STORE = 2'd0,
		REQ_PAD   = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_INIT  = 2'd3
	} lcdr_req_t;

	typedef enum logic [1:0] {
		WAIT_40US  = 2'd0,
		WAIT_150US = 2'd1,
		WAIT_2MS   = 2'd2,
		WAIT_5MS   = 2'd3
	} lcdr_wait_t;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic       text_line;
		logic [3:0] text_column;
		logic [7:0] char_code;
	} lcdr_in_t;

	typedef struct packed {
		logic [3:0] bus_nibble;
		logic       reg_select;
		logic [1:0] wait_code;
		logic       last_nibble;
	} lcdr_out_t;

	typedef struct packed {
		logic cap;
		logic rd_cur;
		logic rd_ref;
		logic wr_store;
		logic wr_space;
		logic adv_ref;
		logic load;
		logic sel_init;
	} lcdr_cmd_t;

	typedef struct packed {
		logic dirty;
		logic cur_in_range;
		logic out_free;
		logic ref_last;
		logic init_last;
	} lcdr_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STORE_RD,
		S_STORE_WR,
		S_PAD_RD,
		S_PAD_WR,
		S_REF_RD,
		S_REF_EMIT,
		S_INIT
	} lcdr_state_t;

	function automatic lcdr_out_t init_word(input logic [3:0] idx);
		lcdr_out_t w;
		w.reg_select  = RS_CMD;
		w.last_nibble = 1'b0;
		w.wait_code   = WAIT_40US;
		w.bus_nibble  = 4'h0;
		unique case (idx)
			4'd0: begin
				w.bus_nibble = 4'h3;
				w.wait_code  = WAIT_5MS;
			end
			4'd1, 4'd2: begin
				w.bus_nibble = 4'h3;
				w.wait_code  = WAIT_150US;
			end
			4'd3: begin
				w.bus_nibble = 4'h2;
				w.wait_code  = WAIT_150US;
			end
			4'd4:  w.bus_nibble = 4'h2;
			4'd5:  w.bus_nibble = 4'h8;
			4'd6:  w.bus_nibble = 4'h0;
			4'd7:  w.bus_nibble = 4'h8;
			4'd8:  w.bus_nibble = 4'h0;
			4'd9: begin
				w.bus_nibble = 4'h1;
				w.wait_code  = WAIT_2MS;
			end
			4'd10: w.bus_nibble = 4'h0;
			4'd11: w.bus_nibble = 4'h6;
			4'd12: w.bus_nibble = 4'h0;
			4'd13: begin
				w.bus_nibble  = 4'hC;
				w.last_nibble = 1'b1;
			end
			default: w.bus_nibble = 4'h0;
		endcase
		return w;
	endfunction

endpackage

[rtl/lcdr_datapath.sv]
module lcdr_datapath import lcdr_pkg::*; #(
	parameter int COLUMNS = LCDR_COLUMNS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lcdr_in_t   cmd_word,
	input  lcdr_cmd_t  cmd,
	output lcdr_stat_t stat,
	output logic       nib_valid,
	input  logic       nib_stall,
	output lcdr_out_t  nib_word
);

	localparam int DEPTH = 2 * COLUMNS;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(COLUMNS + 1);
	localparam int RW = $clog2(COLUMNS);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_q;
	logic             rd_vld_q;
	logic [7:0]       rd_data;

	logic             line_q;
	logic [CW-1:0]    cur_q;
	logic [7:0]       char_q;
	logic [RW-1:0]    ref_col_q;
	logic             ref_line_q;
	logic             dirty_q;
	logic [3:0]       step_q;
	logic             out_valid_q;
	lcdr_out_t        out_q;

	logic [AW-1:0]    cur_addr;
	logic [AW-1:0]    ref_addr;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [7:0]       wr_data;
	logic [7:0]       cmd_byte;
	lcdr_out_t        ref_word;

	assign cur_addr = line_q ? AW'(COLUMNS) + AW'(cur_q) : AW'(cur_q);
	assign ref_addr = ref_line_q ? AW'(COLUMNS) + AW'(ref_col_q) : AW'(ref_col_q);
	assign rd_addr  = cmd.rd_ref ? ref_addr : cur_addr;
	assign rd_data  = rd_vld_q ? rd_q : SPACE_CODE;
	assign wr_en    = cmd.wr_store | cmd.wr_space;
	assign wr_data  = cmd.wr_space ? SPACE_CODE : char_q;
	assign cmd_byte = (ref_line_q ? CMD_LINE1 : CMD_LINE0) + 8'(ref_col_q);

	always_comb begin
		ref_word.wait_code   = WAIT_40US;
		ref_word.last_nibble = 1'b0;
		case (step_q[1:0])
			2'd0: begin
				ref_word.bus_nibble = cmd_byte[7:4];
				ref_word.reg_select = RS_CMD;
			end
			2'd1: begin
				ref_word.bus_nibble = cmd_byte[3:0];
				ref_word.reg_select = RS_CMD;
			end
			2'd2: begin
				ref_word.bus_nibble = rd_data[7:4];
				ref_word.reg_select = RS_DATA;
			end
			default: begin
				ref_word.bus_nibble  = rd_data[3:0];
				ref_word.reg_select  = RS_DATA;
				ref_word.last_nibble = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cur_addr] <= wr_data;
		end
		if (cmd.rd_cur | cmd.rd_ref) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.cap) begin
			char_q <= cmd_word.char_code;
		end
		if (cmd.load) begin
			out_q <= cmd.sel_init ? init_word(step_q) : ref_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			line_q      <= 1'b0;
			cur_q       <= '0;
			ref_col_q   <= '0;
			ref_line_q  <= 1'b0;
			dirty_q     <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_cur | cmd.rd_ref) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[cur_addr] <= 1'b1;
				if (rd_data != wr_data) begin
					dirty_q <= 1'b1;
				end
			end
			if (cmd.cap) begin
				line_q <= cmd_word.text_line;
				cur_q  <= CW'(cmd_word.text_column);
				step_q <= '0;
			end else if (cmd.wr_space) begin
				cur_q <= cur_q + CW'(1);
			end else if (cmd.load) begin
				step_q <= step_q + 4'd1;
			end
			if (cmd.adv_ref) begin
				if (ref_col_q == RW'(COLUMNS - 1)) begin
					ref_col_q <= '0;
					if (ref_line_q) begin
						ref_line_q <= 1'b0;
						dirty_q    <= 1'b0;
					end else begin
						ref_line_q <= 1'b1;
					end
				end else begin
					ref_col_q <= ref_col_q + RW'(1);
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!nib_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.dirty        = dirty_q;
	assign stat.cur_in_range = cur_q < CW'(COLUMNS);
	assign stat.out_free     = !out_valid_q || !nib_stall;
	assign stat.ref_last     = step_q[1:0] == REF_LAST;
	assign stat.init_last    = step_q == INIT_LAST;

	assign nib_valid = out_valid_q;
	assign nib_word  = out_q;

	a_adv_needs_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv_ref |-> dirty_q)
		else $error("refresh position advanced while the buffer was clean");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en || cmd.rd_cur) |-> stat.cur_in_range)
		else $error("buffer access outside the line");

	a_dirty_clear_src: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(dirty_q) |-> $past(cmd.adv_ref) && !$past(ref_line_q) == 1'b0)
		else $error("changed flag cleared outside the end of a refresh pass");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> stat.out_free)
		else $error("output register overwritten while a word waits");

endmodule

[rtl/lcdr_ctrl.sv]
module lcdr_ctrl import lcdr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [1:0] req_type,
	input  lcdr_stat_t stat,
	output lcdr_cmd_t  cmd
);

	lcdr_state_t state_q;
	lcdr_state_t state_d;
	logic        accept;

	assign cmd_stall = state_q != S_IDLE;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.cap = 1'b1;
					unique case (lcdr_req_t'(req_type))
						REQ_STORE: state_d = S_STORE_RD;
						REQ_PAD:   state_d = S_PAD_RD;
						REQ_TICK:  state_d = stat.dirty ? S_REF_RD : S_IDLE;
						REQ_INIT:  state_d = S_INIT;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_STORE_RD: begin
				if (stat.cur_in_range) begin
					cmd.rd_cur = 1'b1;
					state_d    = S_STORE_WR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_STORE_WR: begin
				cmd.wr_store = 1'b1;
				state_d      = S_IDLE;
			end
			S_PAD_RD: begin
				if (stat.cur_in_range) begin
					cmd.rd_cur = 1'b1;
					state_d    = S_PAD_WR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PAD_WR: begin
				cmd.wr_space = 1'b1;
				state_d      = S_PAD_RD;
			end
			S_REF_RD: begin
				cmd.rd_ref = 1'b1;
				state_d    = S_REF_EMIT;
			end
			S_REF_EMIT: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					if (stat.ref_last) begin
						cmd.adv_ref = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			S_INIT: begin
				cmd.sel_init = 1'b1;
				if (stat.out_free) begin
					cmd.load = 1'b1;
					if (stat.init_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_emit_needs_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REF_RD || state_q == S_REF_EMIT) |-> stat.dirty)
		else $error("refresh nibbles sent while the buffer was clean");

endmodule

[rtl/char_lcd_refresh_controller_top.sv]
// Channel   Handshake             Word         Direction
// cmd       cmd_valid/cmd_stall   lcdr_in_t    request into the block
// nib       nib_valid/nib_stall   lcdr_out_t   one bus nibble out of the block
//
// A store reads the cell and then writes it (beyond the line it does neither),
// a pad reads and writes a space per cell walked, a dirty tick reads its cell
// and an init starts at once; both load one nibble per cycle unless nib stalls.
// Reset clears the shadow buffer to spaces at once through per-cell valid bits.
// A stall on nib holds the nibble in progress; cmd is stalled until the
// request in work has finished, but not while its last nibble waits.
module char_lcd_refresh_controller_top import lcdr_pkg::*; #(
	parameter int COLUMNS = LCDR_COLUMNS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  lcdr_in_t  cmd_word,
	output logic      nib_valid,
	input  logic      nib_stall,
	output lcdr_out_t nib_word
);

	lcdr_cmd_t  cmd;
	lcdr_stat_t stat;

	lcdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.req_type  (cmd_word.req_type),
		.stat      (stat),
		.cmd       (cmd)
	);

	lcdr_datapath #(
		.COLUMNS (COLUMNS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_word  (cmd_word),
		.cmd       (cmd),
		.stat      (stat),
		.nib_valid (nib_valid),
		.nib_stall (nib_stall),
		.nib_word  (nib_word)
	);

endmodule
